FILE: sv/smmq_pkg.sv
`default_nettype none

package smmq_pkg;

  // Fixed by the 2-bit queue id and the 3-bit count register
  localparam int unsigned MAX_QUEUES         = 4;
  localparam int unsigned QUEUE_COUNT_RESET  = 4;
  localparam int unsigned DEFAULT_MEM_DEPTH  = 128;
  localparam int unsigned COUNT_W            = 3;
  localparam int unsigned QID_W              = 2;
  localparam int unsigned DATA_W             = 32;
  localparam int unsigned APB_ADDR_W         = 3;
  localparam int unsigned APB_DATA_W         = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_QUEUE_COUNT = 1'b0;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_BAD_QUEUE = 2'd3;

  // Memory command from the pointer control to the datapath
  typedef struct packed {
    logic       write;
    logic       read_ok;
    logic [1:0] status;
  } mem_cmd_t;

endpackage

`default_nettype wire

FILE: sv/smmq_ctrl.sv
`default_nettype none

module smmq_ctrl
  import smmq_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = DEFAULT_MEM_DEPTH,
  localparam int unsigned PW = $clog2(MEM_DEPTH + 1),
  localparam int unsigned AW = $clog2(MEM_DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  step,
  input  wire logic                  op,
  input  wire logic [QID_W-1:0]      qid,
  output mem_cmd_t                   cmd,
  output logic      [AW-1:0]         addr
);

  // Region size for each possible count; unused codes give zero
  localparam int unsigned STEP [8] = '{0, (MEM_DEPTH - 1) / 1, (MEM_DEPTH - 1) / 2,
                                       (MEM_DEPTH - 1) / 3, (MEM_DEPTH - 1) / 4, 0, 0, 0};

  // Pointers are kept one above the address, so the lowest base of -1 reads as 0
  function automatic logic [PW-1:0] region_base(input logic [COUNT_W-1:0] cnt,
                                                input int unsigned k);
    if (k == 0) begin
      return '0;
    end
    return PW'(STEP[cnt] * k + 1);
  endfunction

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [PW-1:0]      head [MAX_QUEUES];
  logic [PW-1:0]      tail [MAX_QUEUES];
  logic [PW-1:0]      base [MAX_QUEUES+1];

  logic               cfg_we;
  logic [PW-1:0]      lo;
  logic [PW-1:0]      hi;
  logic [PW-1:0]      hd;
  logic [PW-1:0]      tl;
  logic [PW-1:0]      hd_m1;

  assign pready = 1'b1;
  assign prdata = APB_DATA_W'(count);
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_QUEUE_COUNT);

  // Clamp the written count into 1..MAX_QUEUES
  always_comb begin
    count_next = pwdata[COUNT_W-1:0];
    if (count_next == '0) begin
      count_next = COUNT_W'(1);
    end else if (count_next > COUNT_W'(MAX_QUEUES)) begin
      count_next = COUNT_W'(MAX_QUEUES);
    end
  end

  always_comb begin
    for (int k = 0; k <= MAX_QUEUES; k++) begin
      base[k] = region_base(count, k);
    end
  end

  always_comb begin
    lo    = base[qid];
    hi    = base[COUNT_W'(qid) + COUNT_W'(1)];
    hd    = head[qid];
    tl    = tail[qid];
    hd_m1 = hd - PW'(1);
    cmd   = '0;
    if ({1'b0, qid} >= count) begin
      cmd.status = ST_BAD_QUEUE;
    end else if (op == OP_ENQ) begin
      if (tl >= hi) begin
        cmd.status = ST_OVERFLOW;
      end else begin
        cmd.status = ST_OK;
        cmd.write  = 1'b1;
      end
    end else begin
      if (hd == lo) begin
        cmd.status = ST_UNDERFLOW;
      end else begin
        cmd.status  = ST_OK;
        cmd.read_ok = 1'b1;
      end
    end
    // tail is one above its address, so its old value is the new word's address
    addr = (op == OP_ENQ) ? tl[AW-1:0] : hd_m1[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= COUNT_W'(QUEUE_COUNT_RESET);
      for (int k = 0; k < MAX_QUEUES; k++) begin
        head[k] <= region_base(COUNT_W'(QUEUE_COUNT_RESET), k);
        tail[k] <= region_base(COUNT_W'(QUEUE_COUNT_RESET), k);
      end
    end else if (cfg_we) begin
      count <= count_next;
      for (int k = 0; k < MAX_QUEUES; k++) begin
        head[k] <= region_base(count_next, k);
        tail[k] <= region_base(count_next, k);
      end
    end else if (step) begin
      if (cmd.write) begin
        if (tl == lo) begin
          head[qid] <= lo + PW'(1);
        end
        tail[qid] <= tl + PW'(1);
      end else if (cmd.read_ok) begin
        // drop the last word: both pointers return to the region base
        if (hd == tl) begin
          head[qid] <= lo;
          tail[qid] <= lo;
        end else begin
          head[qid] <= hd + PW'(1);
        end
      end
    end
  end

  a_write_only_ok: assert property (@(posedge clk) disable iff (rst)
    (cmd.write || cmd.read_ok) |-> (cmd.status == ST_OK))
    else $error("memory access on a failed operation");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(cmd.write && cmd.read_ok))
    else $error("write and read issued for one item");

  a_cfg_reinit: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (head[0] == '0 && tail[0] == '0))
    else $error("queue 0 pointers not reset by count write");

  a_enq_advance: assert property (@(posedge clk) disable iff (rst)
    (step && cmd.write && !cfg_we) |=> (tail[$past(qid)] == $past(tl) + PW'(1)))
    else $error("tail did not advance on enqueue");

endmodule

`default_nettype wire

FILE: sv/shared_memory_multi_queue.sv
// Several linear queues sharing one data memory.
//
// Input channel (in_valid / in_stall): one beat carries opcode (enqueue or
// dequeue), queue_id and write_value. Output channel (out_valid / out_stall):
// one beat per input beat, in order, with status and read_value (the word
// removed by a successful dequeue, zero otherwise).
// Each taken input beat waits in the input register; its result is then held
// in the output register and offered on the output channel.
// Throughput: one beat per cycle unless the output stalls; pointer update and
// memory access for an item happen together, as it leaves the input register.
// A stalled output holds its beat; the input register then holds too and
// in_stall rises, so nothing is lost.
// Config: queue_count at byte address 0 over the APB port; writing it puts
// every queue's pointers back at the base of its region (memory keeps its
// words). Write it only while no beats are in flight.
// Reset: queue_count returns to 4, all queues empty, no clearing pass;
// memory contents are undefined until written.
`default_nettype none

module shared_memory_multi_queue
  import smmq_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = DEFAULT_MEM_DEPTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [APB_ADDR_W-1:0]   paddr,
  input  wire logic [APB_DATA_W-1:0]   pwdata,
  output logic      [APB_DATA_W-1:0]   prdata,
  output logic                         pready,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    opcode,
  input  wire logic [QID_W-1:0]        queue_id,
  input  wire logic signed [DATA_W-1:0] write_value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic      [1:0]              status,
  output logic signed [DATA_W-1:0]     read_value
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  logic              a_valid;
  logic              a_op;
  logic [QID_W-1:0]  a_qid;
  logic [DATA_W-1:0] a_data;

  logic              b_valid;
  logic [1:0]        b_status;
  logic              b_read_ok;
  logic [DATA_W-1:0] rd_data;

  logic              advance;
  logic              step;
  logic              in_fire;
  mem_cmd_t          cmd;
  logic [AW-1:0]     addr;

  logic [DATA_W-1:0] mem [MEM_DEPTH];

  assign advance  = !b_valid || !out_stall;
  assign step     = a_valid && advance;
  assign in_stall = a_valid && !advance;
  assign in_fire  = in_valid && !in_stall;

  smmq_ctrl #(
    .MEM_DEPTH(MEM_DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .step   (step),
    .op     (a_op),
    .qid    (a_qid),
    .cmd    (cmd),
    .addr   (addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!in_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_op   <= opcode;
      a_qid  <= queue_id;
      a_data <= write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_status  <= cmd.status;
      b_read_ok <= a_valid && cmd.read_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (step && cmd.write) begin
      mem[addr] <= a_data;
    end
  end

  // Hold read data while the output beat is stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      rd_data <= mem[addr];
    end
  end

  assign out_valid  = b_valid;
  assign status     = b_status;
  assign read_value = b_read_ok ? rd_data : '0;

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (read_value == '0))
    else $error("nonzero read value on failed operation");

  a_stall_holds_a: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> a_valid)
    else $error("input register lost a beat under stall");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("processed item gave no result");

endmodule

`default_nettype wire

FILE: test/shared_memory_multi_queue_tb.sv
module shared_memory_multi_queue_tb;
  import smmq_pkg::*;

  localparam int MEM_WORDS = 128;
  localparam int PHASE_ITEMS = 210;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] read_value;
  } outcome_t;

  typedef struct packed {
    bit                 set_count;
    logic [COUNT_W-1:0] count_val;
    logic               op;
    logic [QID_W-1:0]   qid;
    logic [DATA_W-1:0]  data;
    bit                 typed;
    outcome_t           want;
  } script_row_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OP_ENQ;
  logic [QID_W-1:0] queue_id = '0;
  logic signed [DATA_W-1:0] write_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic signed [DATA_W-1:0] read_value;

  shared_memory_multi_queue #(.MEM_DEPTH(MEM_WORDS)) uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .queue_id(queue_id), .write_value(write_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .read_value(read_value)
  );

  // Mirror of the queue pointers and the shared memory
  int live_count;
  int head_ix [MAX_QUEUES];
  int tail_ix [MAX_QUEUES];
  logic [DATA_W-1:0] word_store [MEM_WORDS];

  outcome_t pending_outcomes [$];
  outcome_t want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int overflow_seen = 0;
  int underflow_seen = 0;
  int bad_queue_seen = 0;
  int count_writes = 0;
  int quiet_cycles = 0;

  script_row_t script [25] = '{
    '{0, 3'd0, OP_DEQ, 2'd0, 32'h0000_0000, 1, '{ST_UNDERFLOW, 32'h0}},
    '{0, 3'd0, OP_ENQ, 2'd0, 32'h8000_0000, 1, '{ST_OK, 32'h0}},
    '{0, 3'd0, OP_ENQ, 2'd0, 32'h7FFF_FFFF, 1, '{ST_OK, 32'h0}},
    '{0, 3'd0, OP_DEQ, 2'd0, 32'h0000_0000, 1, '{ST_OK, 32'h8000_0000}},
    '{0, 3'd0, OP_DEQ, 2'd0, 32'h0000_0000, 1, '{ST_OK, 32'h7FFF_FFFF}},
    '{0, 3'd0, OP_DEQ, 2'd0, 32'h0000_0000, 1, '{ST_UNDERFLOW, 32'h0}},
    '{0, 3'd0, OP_ENQ, 2'd3, 32'hFFFF_FFFF, 1, '{ST_OK, 32'h0}},
    '{0, 3'd0, OP_ENQ, 2'd2, 32'h0000_0000, 1, '{ST_OK, 32'h0}},
    '{0, 3'd0, OP_DEQ, 2'd3, 32'h0000_0000, 1, '{ST_OK, 32'hFFFF_FFFF}},
    '{0, 3'd0, OP_DEQ, 2'd2, 32'hFFFF_FFFF, 1, '{ST_OK, 32'h0}},
    '{0, 3'd0, OP_ENQ, 2'd1, 32'hA5A5_5A5A, 0, '{ST_OK, 32'h0}},
    '{0, 3'd0, OP_ENQ, 2'd1, 32'h5A5A_A5A5, 0, '{ST_OK, 32'h0}},
    '{0, 3'd0, OP_DEQ, 2'd1, 32'hFFFF_FFFF, 0, '{ST_OK, 32'h0}},
    // a count of zero acts as one queue
    '{1, 3'd0, OP_ENQ, 2'd0, 32'h0000_0000, 0, '{ST_OK, 32'h0}},
    '{0, 3'd0, OP_ENQ, 2'd1, 32'h1111_1111, 1, '{ST_BAD_QUEUE, 32'h0}},
    '{0, 3'd0, OP_DEQ, 2'd3, 32'h0000_0000, 1, '{ST_BAD_QUEUE, 32'h0}},
    '{0, 3'd0, OP_DEQ, 2'd0, 32'h0000_0000, 1, '{ST_UNDERFLOW, 32'h0}},
    '{0, 3'd0, OP_ENQ, 2'd0, 32'h1234_5678, 1, '{ST_OK, 32'h0}},
    '{0, 3'd0, OP_DEQ, 2'd0, 32'h0000_0000, 1, '{ST_OK, 32'h1234_5678}},
    // counts above the maximum clamp to four queues
    '{1, 3'd7, OP_ENQ, 2'd0, 32'h0000_0000, 0, '{ST_OK, 32'h0}},
    '{0, 3'd0, OP_DEQ, 2'd3, 32'h0000_0000, 1, '{ST_UNDERFLOW, 32'h0}},
    '{0, 3'd0, OP_ENQ, 2'd3, 32'h1357_9BDF, 0, '{ST_OK, 32'h0}},
    '{0, 3'd0, OP_DEQ, 2'd3, 32'h0000_0000, 0, '{ST_OK, 32'h0}},
    '{1, 3'd2, OP_ENQ, 2'd0, 32'h0000_0000, 0, '{ST_OK, 32'h0}},
    '{0, 3'd0, OP_ENQ, 2'd2, 32'h0F0F_F0F0, 1, '{ST_BAD_QUEUE, 32'h0}}
  };

  function automatic int region_base(int k);
    if (k == 0) return -1;
    return ((MEM_WORDS - 1) / live_count) * k;
  endfunction

  function automatic void reset_pointers();
    for (int k = 0; k < MAX_QUEUES; k++) begin
      head_ix[k] = region_base(k);
      tail_ix[k] = region_base(k);
    end
  endfunction

  function automatic outcome_t apply_queue_op(logic op, logic [QID_W-1:0] q,
                                              logic [DATA_W-1:0] data);
    outcome_t res;
    int qi;
    int lo;
    int hi;
    res = '{ST_OK, '0};
    qi = int'(q);
    if (qi >= live_count) begin
      res.status = ST_BAD_QUEUE;
    end else begin
      lo = region_base(qi);
      hi = region_base(qi + 1);
      if (op == OP_ENQ) begin
        if (tail_ix[qi] >= hi) begin
          res.status = ST_OVERFLOW;
        end else begin
          if (tail_ix[qi] == lo) head_ix[qi] = lo + 1;
          tail_ix[qi]++;
          word_store[tail_ix[qi]] = data;
        end
      end else begin
        if (head_ix[qi] == lo) begin
          res.status = ST_UNDERFLOW;
        end else begin
          res.read_value = word_store[head_ix[qi]];
          if (head_ix[qi] == tail_ix[qi]) begin
            head_ix[qi] = lo;
            tail_ix[qi] = lo;
          end else begin
            head_ix[qi]++;
          end
        end
      end
    end
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Result check; outputs are settled at the falling edge
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result beat, status %0d read %h", $time, status,
                 read_value);
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status);
          fail_count++;
        end
        if (read_value !== want.read_value) begin
          $display("%0t: read_value expected %h, got %h", $time, want.read_value,
                   read_value);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, pending_outcomes.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic apply_idle_mode(idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 79 : (mode == IDLE_BOTH) ? 33 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 79 : (mode == IDLE_BOTH) ? 33 : 0;
  endtask

  // Called at a rising edge; returns at the edge that took the beat
  task automatic send_beat(logic op, logic [QID_W-1:0] q, logic [DATA_W-1:0] data,
                           bit typed, outcome_t typed_want);
    int gap;
    outcome_t res;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    queue_id <= q;
    write_value <= data;
    do @(negedge clk); while (in_stall !== 1'b0);
    @(posedge clk);
    res = apply_queue_op(op, q, data);
    if (typed) res = typed_want;
    pending_outcomes.push_back(res);
    items_sent++;
    case (res.status)
      ST_OVERFLOW:  overflow_seen++;
      ST_UNDERFLOW: underflow_seen++;
      ST_BAD_QUEUE: bad_queue_seen++;
      default: ;
    endcase
  endtask

  // Drop valid and hold until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_queue_count(logic [COUNT_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_QUEUE_COUNT, 2'b00};
    pwdata <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (pready !== 1'b1);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    live_count = (value == 0) ? 1 : (value > MAX_QUEUES) ? MAX_QUEUES : int'(value);
    reset_pointers();
    count_writes++;
  endtask

  // On live queues, fill runs end in overflow, drain in underflow; rest mixed
  task automatic run_phase(logic [COUNT_W-1:0] count_val, idle_mode_t mode,
                           bit pause_midway);
    int sent;
    int kind;
    int n;
    int q;
    int lo;
    bit paused;
    logic op;
    logic [QID_W-1:0] qid;
    sent = 0;
    paused = 0;
    write_queue_count(count_val);
    apply_idle_mode(mode);
    while (sent < PHASE_ITEMS) begin
      kind = $urandom_range(0, 9);
      q = $urandom_range(0, MAX_QUEUES - 1);
      if (q >= live_count) begin
        n = $urandom_range(1, 3);
      end else if (kind <= 2) begin
        n = region_base(q + 1) - tail_ix[q] + $urandom_range(1, 3);
      end else if (kind <= 5) begin
        lo = region_base(q);
        n = ((head_ix[q] == lo) ? 0 : tail_ix[q] - head_ix[q] + 1) + $urandom_range(1, 2);
      end else begin
        n = $urandom_range(5, 25);
      end
      for (int i = 0; i < n && sent < PHASE_ITEMS; i++) begin
        op = (kind <= 2) ? OP_ENQ : (kind <= 5) ? OP_DEQ : logic'($urandom_range(0, 1));
        qid = (kind == 9) ? QID_W'($urandom_range(0, MAX_QUEUES - 1)) : QID_W'(q);
        send_beat(op, qid, $urandom, 0, '{ST_OK, '0});
        sent++;
      end
      if (pause_midway && !paused && sent >= PHASE_ITEMS / 2) begin
        drain_results();
        paused = 1;
      end
    end
    drain_results();
  endtask

  initial begin
    live_count = QUEUE_COUNT_RESET;
    reset_pointers();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].set_count) begin
        drain_results();
        write_queue_count(script[i].count_val);
      end else begin
        send_beat(script[i].op, script[i].qid, script[i].data, script[i].typed,
                  script[i].want);
      end
    end
    drain_results();

    run_phase(3'd4, IDLE_NONE, 0);
    run_phase(3'd1, IDLE_SENDER, 0);
    run_phase(3'd2, IDLE_RECEIVER, 1);
    run_phase(3'd3, IDLE_BOTH, 0);
    run_phase(3'd0, IDLE_NONE, 0);
    run_phase(3'd7, IDLE_RECEIVER, 0);
    run_phase(3'd5, IDLE_SENDER, 0);
    run_phase(3'd3, IDLE_BOTH, 0);

    apply_idle_mode(IDLE_NONE);
    repeat (10) @(posedge clk);
    $display("%0d beats in, %0d results out over %0d queue-count writes",
             items_sent, results_seen, count_writes);
    $display("overflows %0d, underflows %0d, bad queue ids %0d, mismatches %0d",
             overflow_seen, underflow_seen, bad_queue_seen, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/smmq_pkg.sv
sv/smmq_ctrl.sv
sv/shared_memory_multi_queue.sv
test/shared_memory_multi_queue_tb.sv
